// File: rtl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Types and constants shared by the button debounce event block.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int BTN_W     = 4;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DELAY_RESET = 16'd50;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_GUARD = 2'd1;

  // one raw pin sample
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic              pin_level;
    logic [BTN_W-1:0]  button_index;
  } sample_t;

  // decision for one sample
  typedef struct packed {
    logic             valid;
    logic [BTN_W-1:0] button;
    logic             pressed;
  } result_t;

endpackage

// File: rtl/bde_eval.sv
// ----------------------------------------------------------------------------
// bde_eval
// Per-button state table and the press / release decision for one sample.
// ----------------------------------------------------------------------------
module bde_eval
  import bde_pkg::*;
#(
  parameter int NUM_BUTTONS = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire_i,
  input  sample_t          smp_i,
  input  logic [CFG_W-1:0] debounce_i,
  input  logic [CFG_W-1:0] guard_i,
  output result_t          res_o
);

  localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [6:0] NB = 7'(NUM_BUTTONS);

  logic [NUM_BUTTONS-1:0] acc_r;
  logic [NUM_BUTTONS-1:0] raw_r;
  logic [TIME_W-1:0]      change_r [NUM_BUTTONS];
  logic [TIME_W-1:0]      press_r  [NUM_BUTTONS];

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              acc_cur;
  logic              raw_cur;
  logic [TIME_W-1:0] diff_press;
  logic [TIME_W-1:0] diff_chg;
  logic              press_ok;
  logic              chg_ok;
  logic              do_press;
  logic              do_rel;
  logic              raw_chg;

  assign idx      = IDX_W'(smp_i.button_index);
  assign in_range = {3'b000, smp_i.button_index} < NB;
  assign acc_cur  = acc_r[idx];
  assign raw_cur  = raw_r[idx];

  // wrapped differences, read as signed: negative never passes
  assign diff_press = smp_i.time_ms - press_r[idx];
  assign diff_chg   = smp_i.time_ms - change_r[idx];
  assign press_ok   = !diff_press[TIME_W-1] && (diff_press > {16'h0000, guard_i});
  assign chg_ok     = !diff_chg[TIME_W-1] && (diff_chg > {16'h0000, debounce_i});

  assign do_press = in_range && !smp_i.pin_level && acc_cur && press_ok;
  assign do_rel   = in_range && smp_i.pin_level && !acc_cur && chg_ok;
  assign raw_chg  = in_range && (smp_i.pin_level != raw_cur);

  always_comb begin
    res_o.valid   = do_press || do_rel;
    res_o.button  = smp_i.button_index;
    res_o.pressed = do_press;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      raw_r <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        change_r[i] <= '0;
        press_r[i]  <= '0;
      end
    end else if (fire_i) begin
      if (do_press) begin
        press_r[idx] <= smp_i.time_ms;
        acc_r[idx]   <= 1'b0;
      end
      if (do_rel) begin
        acc_r[idx] <= 1'b1;
      end
      if (raw_chg) begin
        raw_r[idx]    <= smp_i.pin_level;
        change_r[idx] <= smp_i.time_ms;
      end
    end
  end

`ifndef SYNTHESIS
  // accepted level only moves on a processed sample
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire_i |=> $stable(acc_r))
    else $error("accepted level changed without a sample");

  // an event leaves the accepted level opposite to its kind
  a_acc_follow: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && res_o.valid |=> acc_r[$past(idx)] == !$past(res_o.pressed))
    else $error("accepted level does not match event");

  // a raw change stamps the change time
  a_chg_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && raw_chg |=> change_r[$past(idx)] == $past(smp_i.time_ms))
    else $error("change time not updated on raw change");
`endif

endmodule

// File: rtl/button_debounce_event.sv
// ----------------------------------------------------------------------------
// button_debounce_event
// Debouncer for a bank of active-low push buttons, giving press and release
// events from timestamped raw samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw sample per word (button, pin level, ms timestamp).
//   out_* : one event word per accepted level change; tuser = 1 for a press,
//           0 for a release. Samples that change nothing give no word.
//   cfg_* : debounce and repeat guard times, written while the block is idle.
// Path: a sample is held in the input register, decided, and its event word
//   is written to the output register that drives out_tvalid. Throughput: one
//   sample per cycle while out_tready keeps up, set by the single input register
//   -> decision -> output register pass; the button state is updated in the
//   same cycle, so samples of one button may follow directly.
// Reset: all per-button state clears to zero (accepted level reads pressed),
//   both times return to 50 ms, both pipeline registers empty.
// Stall: while out_tready is low with an event waiting, one more sample is
//   held in the input register; in_tready drops after that.
// ----------------------------------------------------------------------------
module button_debounce_event
  import bde_pkg::*;
#(
  parameter int NUM_BUTTONS = 11
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [39:0]          in_tdata,   // button_index[3:0], pin_level, time_ms[31:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // event_button[3:0]
  output logic                 out_tuser,  // event_pressed
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic             in_valid_r;
  sample_t          in_smp_r;
  logic             out_valid_r;
  logic [BTN_W-1:0] out_button_r;
  logic             out_pressed_r;
  logic [CFG_W-1:0] debounce_r;
  logic [CFG_W-1:0] guard_r;
  logic             advance;
  result_t          res;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DELAY_RESET;
      guard_r    <= DELAY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE:     debounce_r <= cfg_wdata;
        REG_REPEAT_GUARD: guard_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_smp_r <= sample_t'(in_tdata[36:0]);
    end
  end

  bde_eval #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_eval (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire_i     (advance),
    .smp_i      (in_smp_r),
    .debounce_i (debounce_r),
    .guard_i    (guard_r),
    .res_o      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_button_r  <= res.button;
      out_pressed_r <= res.pressed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'h0, out_button_r};
  assign out_tuser  = out_pressed_r;

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for button_debounce_event. A per-button debounce
// predictor mirrors every accepted sample word and queues the expected press
// and release events; a checker compares each event word against the queue.
// Directed cases cover reset levels, time wrap, the signed time check,
// ignored button numbers and register extremes. Random phases follow under
// several settings, with bursts of idling on both sides, one long receiver
// stall and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import bde_pkg::*;

  localparam int NUM_BUTTONS = 11;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [39:0]          in_tdata;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;
  logic                 out_tuser;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  button_debounce_event #(.NUM_BUTTONS(NUM_BUTTONS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [CFG_W-1:0]  cur_debounce;
  logic [CFG_W-1:0]  cur_guard;
  logic              acc_lvl  [NUM_BUTTONS];
  logic              raw_lvl  [NUM_BUTTONS];
  logic [TIME_W-1:0] chg_time [NUM_BUTTONS];
  logic [TIME_W-1:0] prs_time [NUM_BUTTONS];
  result_t           event_q[$];

  // stimulus-side view of each button's timeline (16 so ignored numbers fit)
  logic [TIME_W-1:0] gen_time [16];
  logic [TIME_W-1:0] gen_mark [16];
  bit                gen_lvl  [16];

  int  mismatch_cnt;
  int  sink_hold;
  bit  idle_en;

  function automatic bit elapsed_over_limit(logic [TIME_W-1:0] now, logic [TIME_W-1:0] then,
                                            logic [CFG_W-1:0] lim);
    logic [TIME_W-1:0] d;
    d = now - then;
    return !d[TIME_W-1] && (d > {16'b0, lim});
  endfunction

  task automatic debounce_step(logic [BTN_W-1:0] b, logic lvl, logic [TIME_W-1:0] t);
    result_t ev;
    if (b >= NUM_BUTTONS) return;
    ev = '0;
    if (!lvl && acc_lvl[b]) begin
      if (elapsed_over_limit(t, prs_time[b], cur_guard)) begin
        prs_time[b] = t;
        acc_lvl[b]  = 1'b0;
        ev.valid    = 1'b1;
        ev.pressed  = 1'b1;
      end
    end else if (lvl && !acc_lvl[b]) begin
      if (elapsed_over_limit(t, chg_time[b], cur_debounce)) begin
        acc_lvl[b] = 1'b1;
        ev.valid   = 1'b1;
        ev.pressed = 1'b0;
      end
    end
    if (lvl != raw_lvl[b]) begin
      chg_time[b] = t;
      raw_lvl[b]  = lvl;
    end
    if (ev.valid) begin
      ev.button = b;
      event_q.push_back(ev);
    end
  endtask

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // one sample word; called and returns on a falling edge
  task automatic send_sample(logic [BTN_W-1:0] b, logic lvl, logic [TIME_W-1:0] t);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_tdata  <= {3'b000, t, lvl, b};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    debounce_step(b, lvl, t);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    wait (event_q.size() == 0);
    // samples without an event may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_DEBOUNCE) cur_debounce = val;
    else if (idx == REG_REPEAT_GUARD) cur_guard = val;
  endtask

  task automatic send_random(int n);
    int k;
    int thr;
    logic [BTN_W-1:0] b;
    bit lvl;
    logic [TIME_W-1:0] t;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 24) == 0) b = 4'($urandom_range(NUM_BUTTONS, 15));
      else b = 4'($urandom_range(0, NUM_BUTTONS - 1));
      lvl = ($urandom_range(0, 2) == 0) ? gen_lvl[b] : ~gen_lvl[b];
      thr = $urandom_range(0, 1) ? int'(cur_debounce) : int'(cur_guard);
      case ($urandom_range(0, 9))
        0, 1:    t = gen_time[b] + $urandom_range(0, 3);
        2, 3, 4: t = gen_mark[b] + thr - 2 + $urandom_range(0, 4);
        5, 6, 7: t = gen_time[b] + $urandom_range(0, thr * 2 + 8);
        8:       t = gen_time[b] + $urandom_range(0, 200000);
        default: t = $urandom();
      endcase
      if (lvl != gen_lvl[b]) gen_mark[b] = t;
      gen_lvl[b]  = lvl;
      gen_time[b] = t;
      send_sample(b, lvl, t);
      if (b < NUM_BUTTONS) k++;
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_reset_levels();
    // accepted level starts at pressed, so the first quiet high releases
    send_sample(4'd0, 1'b1, 32'd50);
    send_sample(4'd0, 1'b1, 32'd101);
    send_sample(4'd0, 1'b0, 32'd102);
    send_sample(4'd0, 1'b0, 32'd103);
    send_sample(4'd0, 1'b1, 32'd153);
    send_sample(4'd0, 1'b0, 32'd152);  // time steps back, guard not met
    send_sample(4'd0, 1'b0, 32'd153);
    // wrap and sign of the time difference
    send_sample(4'd10, 1'b1, 32'hFFFF_FFFF);
    send_sample(4'd10, 1'b1, 32'h0000_0032);
    send_sample(4'd10, 1'b0, 32'h8000_0000);
    send_sample(4'd10, 1'b0, 32'h7FFF_FFFF);
    // out of range buttons are ignored
    send_sample(4'd11, 1'b1, 32'd1000);
    send_sample(4'd15, 1'b0, 32'd0);
    send_sample(4'd5, 1'b0, 32'd0);
    send_sample(4'd5, 1'b1, 32'd51);
  endtask

  task automatic test_register_extremes();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_REPEAT_GUARD, 16'd0);
    send_sample(4'd1, 1'b1, 32'd100);
    send_sample(4'd1, 1'b0, 32'd100);
    send_sample(4'd1, 1'b1, 32'd100);
    send_sample(4'd1, 1'b1, 32'd101);
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_REPEAT_GUARD, 16'hFFFF);
    // unused indexes must leave both times alone
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'h0000);
    send_sample(4'd2, 1'b1, 32'd65535);
    send_sample(4'd2, 1'b1, 32'd131071);
    send_sample(4'd2, 1'b0, 32'd65535);
    send_sample(4'd2, 1'b0, 32'd65536);
  endtask

  task automatic test_random_settings();
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_REPEAT_GUARD, 16'd0);
    send_random(300);
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_REPEAT_GUARD, 16'hFFFF);
    send_random(250);
    write_reg(REG_DEBOUNCE, 16'd0);
    send_random(250);
    write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_REPEAT_GUARD, 16'd0);
    send_random(250);
    write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 300)));
    write_reg(REG_REPEAT_GUARD, 16'($urandom()));
    send_random(250);
  endtask

  task automatic test_backpressure();
    int i;
    logic [BTN_W-1:0] b;
    write_reg(REG_DEBOUNCE, 16'd0);
    write_reg(REG_REPEAT_GUARD, 16'd0);
    idle_en = 1'b0;
    @(posedge clk);
    sink_hold = 200;
    @(negedge clk);
    // every toggle with time moving forward gives an event at zero times
    for (i = 0; i < 40; i++) begin
      b = 4'(i % NUM_BUTTONS);
      gen_lvl[b]  = ~gen_lvl[b];
      gen_time[b] = gen_time[b] + 1 + $urandom_range(0, 9);
      gen_mark[b] = gen_time[b];
      send_sample(b, gen_lvl[b], gen_time[b]);
    end
    idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    write_reg(REG_DEBOUNCE, DELAY_RESET);
    write_reg(REG_REPEAT_GUARD, 16'($urandom_range(0, 100)));
    send_random(20);
    in_tvalid <= 1'b0;
    wait (event_q.size() == 0);
    @(negedge clk);
    send_random(20);
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    write_reg(REG_DEBOUNCE, 16'($urandom_range(0, 120)));
    write_reg(REG_REPEAT_GUARD, 16'($urandom_range(0, 120)));
    send_random(380);
  endtask

  // --------------------------------------------------------------------------
  // receiver: random stall bursts plus an optional long hold
  // --------------------------------------------------------------------------
  initial begin : sink
    int gap;
    gap = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_tready <= 1'b0;
        sink_hold--;
      end else if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(0, 4);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // event checker
  initial begin : ev_check
    result_t exp_ev;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (event_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected event word tdata=%h tuser=%b",
                                  out_tdata, out_tuser));
        end else begin
          exp_ev = event_q.pop_front();
          if (out_tdata !== {4'b0000, exp_ev.button} || out_tuser !== exp_ev.pressed)
            flag_mismatch($sformatf("expected button=%0d pressed=%b, got tdata=%h tuser=%b",
                                    exp_ev.button, exp_ev.pressed, out_tdata, out_tuser));
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin : main
    int i;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    mismatch_cnt = 0;
    sink_hold    = 0;
    idle_en      = 1'b1;
    cur_debounce = DELAY_RESET;
    cur_guard    = DELAY_RESET;
    for (i = 0; i < NUM_BUTTONS; i++) begin
      acc_lvl[i]  = 1'b0;
      raw_lvl[i]  = 1'b0;
      chg_time[i] = '0;
      prs_time[i] = '0;
    end
    for (i = 0; i < 16; i++) begin
      gen_time[i] = $urandom();
      gen_mark[i] = gen_time[i];
      gen_lvl[i]  = 1'b0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_levels();
    test_register_extremes();
    test_random_settings();
    test_backpressure();
    test_drain_pause();
    test_no_idle();

    in_tvalid <= 1'b0;
    wait (event_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && event_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: button_debounce_event.f
rtl/bde_pkg.sv
rtl/bde_eval.sv
rtl/button_debounce_event.sv
dv/tb_top.sv
